@@ hdl/largest_prime_factor_unit_assert.svh @@
// Assertion macros shared by the largest prime factor unit's modules.
`ifndef LARGEST_PRIME_FACTOR_UNIT_ASSERT_SVH
`define LARGEST_PRIME_FACTOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define LPF_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lpf assertion failed");

// Next-cycle implication, checked outside of reset.
`define LPF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lpf assertion failed");

`endif

@@ hdl/lpf_pkg.sv @@
// Package with the microcode format, step addresses and control store of the factor unit.
package lpf_pkg;

	localparam int unsigned STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	// Constants of the trial division.
	localparam int unsigned LPF_TWO       = 2;
	localparam int unsigned LPF_FIRST_ODD = 3;

	// Datapath operations, one per control word.
	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_HALVE,
		OP_DIV,
		OP_TAKE,
		OP_NEXT_D,
		OP_FINAL,
		OP_PUBLISH
	} op_t;

	// Jump conditions; when the condition holds the sequencer jumps, else it steps on.
	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_VALID,
		C_NO_FACTOR,
		C_ODD,
		C_DIV_BUSY,
		C_D_GT_Q,
		C_REM_NZ,
		C_OUT_FULL
	} cond_t;

	typedef struct packed {
		logic  rdy;
		op_t   op;
		cond_t cond;
		step_t target;
	} uword_t;

	localparam step_t S_IDLE     = 4'd0;
	localparam step_t S_CHECK    = 4'd1;
	localparam step_t S_EVEN     = 4'd2;
	localparam step_t S_HALVE    = 4'd3;
	localparam step_t S_TRIAL    = 4'd4;
	localparam step_t S_WAIT_DIV = 4'd5;
	localparam step_t S_TEST_END = 4'd6;
	localparam step_t S_TEST_REM = 4'd7;
	localparam step_t S_TAKE     = 4'd8;
	localparam step_t S_NEXT     = 4'd9;
	localparam step_t S_FINAL    = 4'd10;
	localparam step_t S_OUT_WAIT = 4'd11;
	localparam step_t S_PUBLISH  = 4'd12;

	// Control store.
	function automatic uword_t ucode(step_t s);
		uword_t w;
		w = '{rdy: 1'b0, op: OP_NOP, cond: C_ALWAYS, target: S_IDLE};
		unique case (s)
			S_IDLE:     w = '{rdy: 1'b1, op: OP_LOAD,    cond: C_NO_VALID,  target: S_IDLE};
			S_CHECK:    w = '{rdy: 1'b0, op: OP_NOP,     cond: C_NO_FACTOR, target: S_OUT_WAIT};
			S_EVEN:     w = '{rdy: 1'b0, op: OP_NOP,     cond: C_ODD,       target: S_TRIAL};
			S_HALVE:    w = '{rdy: 1'b0, op: OP_HALVE,   cond: C_ALWAYS,    target: S_EVEN};
			S_TRIAL:    w = '{rdy: 1'b0, op: OP_DIV,     cond: C_NEVER,     target: S_IDLE};
			S_WAIT_DIV: w = '{rdy: 1'b0, op: OP_NOP,     cond: C_DIV_BUSY,  target: S_WAIT_DIV};
			S_TEST_END: w = '{rdy: 1'b0, op: OP_NOP,     cond: C_D_GT_Q,    target: S_FINAL};
			S_TEST_REM: w = '{rdy: 1'b0, op: OP_NOP,     cond: C_REM_NZ,    target: S_NEXT};
			S_TAKE:     w = '{rdy: 1'b0, op: OP_TAKE,    cond: C_ALWAYS,    target: S_TRIAL};
			S_NEXT:     w = '{rdy: 1'b0, op: OP_NEXT_D,  cond: C_ALWAYS,    target: S_TRIAL};
			S_FINAL:    w = '{rdy: 1'b0, op: OP_FINAL,   cond: C_NEVER,     target: S_IDLE};
			S_OUT_WAIT: w = '{rdy: 1'b0, op: OP_NOP,     cond: C_OUT_FULL,  target: S_OUT_WAIT};
			S_PUBLISH:  w = '{rdy: 1'b0, op: OP_PUBLISH, cond: C_ALWAYS,    target: S_IDLE};
			default:    w = '{rdy: 1'b0, op: OP_NOP,     cond: C_ALWAYS,    target: S_IDLE};
		endcase
		return w;
	endfunction

endpackage

@@ hdl/lpf_in_if.sv @@
// Input channel interface carrying the number to factor.
interface lpf_in_if #(
	parameter int unsigned WIDTH = 32
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] number;

	modport source (output valid, output number, input ready);
	modport sink   (input valid, input number, output ready);
endinterface

@@ hdl/lpf_out_if.sv @@
// Output channel interface carrying the largest prime factor and the no-factor flag.
interface lpf_out_if #(
	parameter int unsigned WIDTH = 32
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] largest_factor;
	logic             no_factor;

	modport source (output valid, output largest_factor, output no_factor, input ready);
	modport sink   (input valid, input largest_factor, input no_factor, output ready);
endinterface

@@ hdl/lpf_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
module lpf_div #(
	parameter int unsigned WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic             busy,
	output logic [WIDTH-1:0] quot,
	output logic [WIDTH-1:0] rem
);
	localparam int unsigned CNT_W = $clog2(WIDTH + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quot_q;
	logic [WIDTH-1:0] dvs_q;
	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;
	logic             fits;

	assign trial = {rem_q, quot_q[WIDTH-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(WIDTH);
		end else if (busy) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= dividend;
			dvs_q  <= divisor;
		end else if (busy) begin
			rem_q  <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
			quot_q <= {quot_q[WIDTH-2:0], fits};
		end
	end

	assign busy = cnt_q != '0;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

@@ hdl/lpf_core.sv @@
// Microcoded sequencer and datapath registers of the trial-division search.
`include "largest_prime_factor_unit_assert.svh"

module lpf_core #(
	parameter int unsigned WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] number,
	input  logic             out_full,
	output logic             publish,
	output logic [WIDTH-1:0] factor,
	output logic             no_factor
);
	import lpf_pkg::*;

	step_t            pc_q;
	step_t            pc_next;
	uword_t           uw;
	logic             jump;
	logic             accept;

	logic [WIDTH-1:0] n_q;
	logic [WIDTH-1:0] d_q;
	logic [WIDTH-1:0] best_q;
	logic             nf_q;

	logic             div_start;
	logic             div_busy;
	logic [WIDTH-1:0] div_quot;
	logic [WIDTH-1:0] div_rem;

	assign uw       = ucode(pc_q);
	assign in_ready = uw.rdy;
	assign accept   = in_valid && uw.rdy;

	// Condition select.
	always_comb begin
		unique case (uw.cond)
			C_NEVER:     jump = 1'b0;
			C_ALWAYS:    jump = 1'b1;
			C_NO_VALID:  jump = !in_valid;
			C_NO_FACTOR: jump = nf_q;
			C_ODD:       jump = n_q[0];
			C_DIV_BUSY:  jump = div_busy;
			C_D_GT_Q:    jump = d_q > div_quot;
			C_REM_NZ:    jump = div_rem != '0;
			C_OUT_FULL:  jump = out_full;
			default:     jump = 1'b1;
		endcase
	end

	always_comb begin
		pc_next = jump ? uw.target : pc_q + step_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

	// Datapath registers, each updated by the operation of the current control word.
	always_ff @(posedge clk) begin
		unique case (uw.op)
			OP_LOAD: begin
				n_q    <= number;
				d_q    <= WIDTH'(LPF_FIRST_ODD);
				best_q <= '0;
				nf_q   <= number[WIDTH-1:1] == '0;
			end
			OP_HALVE: begin
				n_q    <= {1'b0, n_q[WIDTH-1:1]};
				best_q <= WIDTH'(LPF_TWO);
			end
			OP_TAKE: begin
				n_q    <= div_quot;
				best_q <= d_q;
			end
			OP_NEXT_D: begin
				d_q <= d_q + WIDTH'(LPF_TWO);
			end
			OP_FINAL: begin
				if (n_q > WIDTH'(LPF_TWO)) begin
					best_q <= n_q;
				end
			end
			OP_NOP, OP_DIV, OP_PUBLISH: begin
			end
			default: begin
			end
		endcase
	end

	assign div_start = uw.op == OP_DIV;
	assign publish   = uw.op == OP_PUBLISH;
	assign factor    = best_q;
	assign no_factor = nf_q;

	lpf_div #(
		.WIDTH(WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (n_q),
		.divisor  (d_q),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	`LPF_ASSERT_IMPL(a_div_start_idle, div_start, !div_busy)
	`LPF_ASSERT_NEXT(a_accept_to_check, accept, pc_q == S_CHECK)
	`LPF_ASSERT_IMPL(a_publish_free, publish, !out_full)
	`LPF_ASSERT_IMPL(a_pc_in_program, 1'b1, pc_q <= S_PUBLISH)

endmodule

@@ hdl/largest_prime_factor_unit.sv @@
// Largest prime factor by trial division: an input transaction gives one result transaction.
// After acceptance, factors of two are halved out and odd trial divisors are then tried
// until the divisor exceeds the quotient of its trial; zero and one skip the search.
// The worst case is a WIDTH-bit prime.
// The search takes one item at a time; the single divider sets the pace of each trial.
// Reset clears the step counter, divider counter and result valid; no clearing pass is needed.
`include "largest_prime_factor_unit_assert.svh"

module largest_prime_factor_unit #(
	parameter int unsigned WIDTH = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	lpf_in_if.sink    operand,
	lpf_out_if.source result
);
	import lpf_pkg::*;

	// The sequencer runs the search; this level holds the finished result in an output
	// register so that the next transaction can be accepted while the result waits.
	logic             publish;
	logic [WIDTH-1:0] core_factor;
	logic             core_nf;

	logic             res_valid_q;
	logic [WIDTH-1:0] res_factor_q;
	logic             res_nf_q;

	lpf_core #(
		.WIDTH(WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (operand.valid),
		.in_ready  (operand.ready),
		.number    (operand.number),
		.out_full  (res_valid_q),
		.publish   (publish),
		.factor    (core_factor),
		.no_factor (core_nf)
	);

	// The result register fills when the sequencer publishes and empties when the
	// result transaction completes. The microcode only publishes into an empty register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (publish) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (publish) begin
			res_factor_q <= core_factor;
			res_nf_q     <= core_nf;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.largest_factor = res_factor_q;
	assign result.no_factor      = res_nf_q;

	`LPF_ASSERT_NEXT(a_publish_fills, publish, res_valid_q)
	`LPF_ASSERT_IMPL(a_no_factor_zero, res_valid_q && res_nf_q, res_factor_q == '0)
	`LPF_ASSERT_IMPL(a_factor_present, res_valid_q && !res_nf_q, res_factor_q != '0)

endmodule

@@ verif/factor_monitor.sv @@
// Checker that predicts the largest prime factor of each accepted number and compares results.
`timescale 1ns / 1ps

module factor_monitor #(
	parameter int unsigned WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	lpf_in_if    operand,
	lpf_out_if   result,
	output int   errors,
	output int   pending,
	output int   checked,
	output int   stalls
);

	typedef struct packed {
		logic [WIDTH-1:0] largest_factor;
		logic             no_factor;
	} factor_result_t;

	factor_result_t factor_q[$];
	factor_result_t want;
	int err_count   = 0;
	int waiting     = 0;
	int seen_count  = 0;
	int stall_count = 0;

	assign errors  = err_count;
	assign pending = waiting;
	assign checked = seen_count;
	assign stalls  = stall_count;

	// Trial division on a wide copy of the value, so the divisor test cannot overflow.
	function automatic factor_result_t predict_factor(logic [WIDTH-1:0] number);
		factor_result_t r;
		logic [63:0]    rest;
		logic [63:0]    d;
		logic [63:0]    best;
		r.no_factor = (number < lpf_pkg::LPF_TWO);
		r.largest_factor = '0;
		if (r.no_factor)
			return r;
		rest = 64'(number);
		best = '0;
		while (rest[0] == 1'b0) begin
			best = 64'(lpf_pkg::LPF_TWO);
			rest = rest >> 1;
		end
		for (d = 64'(lpf_pkg::LPF_FIRST_ODD); d <= rest / d; d = d + 64'd2) begin
			while (rest % d == 64'd0) begin
				best = d;
				rest = rest / d;
			end
		end
		if (rest > lpf_pkg::LPF_TWO)
			best = rest;
		r.largest_factor = best[WIDTH-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] exp_v,
			input logic [63:0] got_v);
		$display("factor_monitor: %s: expected %0d, got %0d at %0t", what, exp_v, got_v,
			$realtime);
		err_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (operand.valid && operand.ready)
				factor_q = {factor_q, predict_factor(operand.number)};
			if (operand.valid && !operand.ready)
				stall_count++;
			if (result.valid && result.ready) begin
				if (factor_q.size() == 0) begin
					report_mismatch("result with no number outstanding", 64'd0,
						64'(result.largest_factor));
				end else begin
					want = factor_q.pop_front();
					if (result.largest_factor !== want.largest_factor)
						report_mismatch("largest_factor", 64'(want.largest_factor),
							64'(result.largest_factor));
					if (result.no_factor !== want.no_factor)
						report_mismatch("no_factor", 64'(want.no_factor),
							64'(result.no_factor));
					seen_count++;
				end
			end
			waiting = factor_q.size();
		end
	end

endmodule

@@ verif/tb.sv @@
// Top of the largest prime factor testbench: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;

	localparam int unsigned WIDTH = 32;

	// Trial divisions allowed per random number. A 32-bit prime would need about 32k
	// divisions, so random numbers are kept well below that.
	localparam int COST_CAP     = 600;
	localparam int RANDOM_ITEMS = 75;
	localparam int HOLD_CYCLES  = 6000;
	localparam int BURST_ITEMS  = 5;

	// Worst correct run: about 100 numbers of up to COST_CAP trial divisions each, plus stalls.
	// Taken about five times over.
	localparam int CYCLE_LIMIT  = 12_000_000;

	localparam int CORNER_COUNT = 20;

	logic clk;
	logic arst_n;

	int tx_idle;
	int rx_idle;
	int hold_left  = 0;
	bit hold_req   = 1'b0;
	bit hold_taken = 1'b0;
	int cycles     = 0;
	int sent;

	int errors;
	int pending;
	int checked;
	int stalls;

	// Directed numbers: zero and one (no factor), small primes, squares of primes,
	// powers of two, all ones and all zeros, alternating bit patterns, a 16-bit and a
	// 20-bit prime, a large power of three (many repeated divisions) and a 16-bit prime
	// shifted left so that halving and odd trials both matter.
	logic [WIDTH-1:0] corner_numbers [0:CORNER_COUNT-1] = '{
		32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd9, 32'd15, 32'd25, 32'd49,
		32'd97, 32'd1024, 32'h8000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
		32'd65521, 32'd1048573, 32'd3486784401, 32'd4293984256
	};

	lpf_in_if  #(.WIDTH(WIDTH)) operand_ch ();
	lpf_out_if #(.WIDTH(WIDTH)) result_ch ();

	largest_prime_factor_unit #(.WIDTH(WIDTH)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.operand(operand_ch),
		.result (result_ch)
	);

	factor_monitor #(.WIDTH(WIDTH)) mon (
		.clk    (clk),
		.arst_n (arst_n),
		.operand(operand_ch),
		.result (result_ch),
		.errors (errors),
		.pending(pending),
		.checked(checked),
		.stalls (stalls)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Global watchdog. A hung block never gets past the limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// Result side flow control. Normally ready drops at random with the current idle
	// rate. When a hold is requested, ready stays low while a counter loaded from
	// HOLD_CYCLES runs down, so that a finished result sits in the block and the input backs up.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			result_ch.ready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (hold_req && !hold_taken) begin
			result_ch.ready <= 1'b0;
			hold_left = HOLD_CYCLES - 1;
			hold_taken = 1'b1;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	// Number of odd trial divisors the search runs through for n, stopping early once
	// the count passes COST_CAP. This keeps the run time of random numbers bounded.
	function automatic int trial_steps(logic [WIDTH-1:0] n);
		logic [63:0] rest;
		logic [63:0] d;
		int          steps;
		if (n < 2)
			return 0;
		rest = 64'(n);
		steps = 0;
		while (rest[0] == 1'b0)
			rest = rest >> 1;
		for (d = 64'd3; d <= rest / d; d = d + 64'd2) begin
			steps++;
			if (steps > COST_CAP)
				return steps;
			while (rest % d == 64'd0)
				rest = rest / d;
		end
		return steps;
	endfunction

	// Random numbers come in four flavors: full 32-bit values (only those whose search
	// ends soon), small values including zero and one, products of small factors, and
	// a moderate cofactor shifted left by a random amount.
	function automatic logic [WIDTH-1:0] pick_number();
		logic [63:0] v;
		logic [63:0] f;
		int          kind;
		kind = $urandom_range(99);
		do begin
			if (kind < 35) begin
				v = 64'($urandom);
			end else if (kind < 60) begin
				v = 64'($urandom_range(4095));
			end else if (kind < 85) begin
				v = 64'd1;
				repeat ($urandom_range(1, 8)) begin
					f = 64'($urandom_range(2, 300));
					if (v * f < 64'h1_0000_0000)
						v = v * f;
				end
			end else begin
				v = 64'($urandom_range(2, 200000)) << $urandom_range(0, 14);
			end
		end while (trial_steps(v[WIDTH-1:0]) > COST_CAP);
		return v[WIDTH-1:0];
	endfunction

	// Offer one number, idling first with the current rate. Called and returns at a
	// falling edge; valid is left high so back-to-back numbers stay back to back.
	task automatic send_number(input logic [WIDTH-1:0] n);
		while ($urandom_range(99) < tx_idle) begin
			operand_ch.valid <= 1'b0;
			operand_ch.number <= $urandom;
			@(negedge clk);
		end
		operand_ch.valid <= 1'b1;
		operand_ch.number <= n;
		@(posedge clk);
		while (!operand_ch.ready)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	initial begin
		operand_ch.valid = 1'b0;
		operand_ch.number = '0;
		tx_idle = 32;
		rx_idle = 82;
		sent = 0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed corner cases first, under the first idling mix.
		for (int i = 0; i < CORNER_COUNT; i++)
			send_number(corner_numbers[i]);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// Swap the idling rates a third of the way in; in the last third nobody idles.
			if (i == RANDOM_ITEMS / 3) begin
				tx_idle = 82;
				rx_idle = 32;
			end
			if (i == 2 * RANDOM_ITEMS / 3) begin
				tx_idle = 0;
				rx_idle = 0;
				// Back-pressure burst: once the block is idle, the result side holds off
				// for a long stretch while quick numbers keep coming, so the block fills
				// and refuses input.
				operand_ch.valid <= 1'b0;
				while (pending != 0)
					@(negedge clk);
				hold_req = 1'b1;
				for (int k = 0; k < BURST_ITEMS; k++)
					send_number($urandom_range(2, 4095));
			end
			send_number(pick_number());
		end
		operand_ch.valid <= 1'b0;

		// Drain, then give the block a little time to show any stray result.
		while (pending != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);

		$display("summary: %0d numbers factored (%0d directed, the rest random),", sent,
			CORNER_COUNT);
		$display("summary: %0d results checked, %0d cycles of input stalled, %0d errors",
			checked, stalls, errors);
		if (errors == 0 && pending == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
